// ----- src/lbvf_pkg.sv -----
// Shared types and constants of the learning bridge forwarding engine.
// Depends on nothing; every other file but lbvf_ram uses it by scoped names.
`default_nettype none
package lbvf_pkg;

    localparam int KEY_W  = 60;
    localparam int HASH_W = 20;

    typedef struct packed {
        logic        cmd;
        logic [13:0] frame_length;
        logic [15:0] outer_type;
        logic [15:0] tag_control;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [63:0] now_ns;
        logic [5:0]  member_word_index;
        logic [63:0] member_word_bits;
    } in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  out_port;
        logic [1:0]  tag_edit;
        logic [11:0] frame_vlan;
        logic [2:0]  drop_reason;
    } out_t;

    localparam logic CMD_MEMBER = 1'b1;

    localparam logic [2:0] ACT_DROP     = 3'd0;
    localparam logic [2:0] ACT_PASS     = 3'd1;
    localparam logic [2:0] ACT_REDIRECT = 3'd2;
    localparam logic [2:0] ACT_HOOK     = 3'd3;
    localparam logic [2:0] ACT_CFG_DONE = 3'd4;

    localparam logic [1:0] EDIT_NONE = 2'd0;
    localparam logic [1:0] EDIT_PUSH = 2'd1;
    localparam logic [1:0] EDIT_POP  = 2'd2;

    localparam logic [2:0] DROP_NONE     = 3'd0;
    localparam logic [2:0] DROP_SHORT    = 3'd1;
    localparam logic [2:0] DROP_BAD_VLAN = 3'd2;
    localparam logic [2:0] DROP_NOT_MEM  = 3'd3;
    localparam logic [2:0] DROP_QINQ     = 3'd4;
    localparam logic [2:0] DROP_NO_IPV4  = 3'd5;

    localparam logic [2:0] CFG_OWN_PORT  = 3'd0;
    localparam logic [2:0] CFG_PORT_VLAN = 3'd1;
    localparam logic [2:0] CFG_FILTER    = 3'd2;
    localparam logic [2:0] CFG_HOOK      = 3'd3;
    localparam logic [2:0] CFG_MAX_AGE   = 3'd4;

    localparam logic [15:0] TPID_Q       = 16'h8100;
    localparam logic [15:0] TPID_AD      = 16'h88a8;
    localparam logic [11:0] VID_MAX      = 12'd4094;
    localparam logic [7:0]  BCAST_OCTET  = 8'hff;
    localparam logic [39:0] MAX_AGE_INIT = 40'd300000000000;
    localparam logic [11:0] PVID_INIT    = 12'd1;

    localparam logic [13:0] LEN_UNTAGGED = 14'd14;
    localparam logic [13:0] LEN_TAGGED   = 14'd18;
    localparam logic [13:0] LEN_IP_UNTAG = 14'd34;
    localparam logic [13:0] LEN_IP_TAG   = 14'd38;

    // Fold a 60-bit key into 20 bits by xor of its three slices.
    function automatic logic [HASH_W-1:0] fold_key(input logic [KEY_W-1:0] key);
        return key[19:0] ^ key[39:20] ^ key[59:40];
    endfunction

endpackage
`default_nettype wire

// ----- src/lbvf_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module lbvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/lbvf_set_mod.sv -----
// Reduces a 20-bit hash modulo the set count: a mask for a power of two,
// otherwise a registered reciprocal multiplication and back-multiply.
// Depends on lbvf_pkg.
`default_nettype none
module lbvf_set_mod #(
    parameter int DIVISOR = 256,
    parameter int OUT_W   = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lbvf_pkg::HASH_W-1:0] value,
    output logic                             done,
    output logic      [OUT_W-1:0]            rem
);
    localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             done_reg;
            logic [OUT_W-1:0] rem_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    rem_reg <= OUT_W'(value & lbvf_pkg::HASH_W'(DIVISOR - 1));
                end
            end
            assign done = done_reg;
            assign rem  = rem_reg;
        end else begin : g_recip
            // The quotient is floor(value * M / 2^S) with M rounded up; with
            // S = 20 + ceil(log2(DIVISOR)) it is exact for every 20-bit value.
            localparam int HW = lbvf_pkg::HASH_W;
            localparam int L  = $clog2(DIVISOR);
            localparam int S  = HW + L;
            localparam int MW = HW + 1;
            localparam int PW = HW + MW;
            localparam logic [63:0] RECIP =
                ((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
            localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];
            localparam logic [HW-1:0] DIV_C   = HW'(DIVISOR);

            logic             stage_reg;
            logic             done_reg;
            logic [HW-1:0]    val_reg;
            logic [HW-1:0]    quo_reg;
            logic [OUT_W-1:0] rem_reg;
            logic [PW-1:0]    prod;
            logic [HW-1:0]    quo_next;
            logic [HW-1:0]    back;

            always_comb begin
                prod     = PW'(value) * PW'(RECIP_M);
                quo_next = HW'(prod >> S);
                back     = quo_reg * DIV_C;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end else begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
                if (start) begin
                    val_reg <= value;
                    quo_reg <= quo_next;
                end
                if (stage_reg) begin
                    rem_reg <= OUT_W'(val_reg - back);
                end
            end
            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate
endmodule
`default_nettype wire

// ----- src/l2_learning_bridge_vlan_fdb_unit.sv -----
// Top level of the learning bridge ingress engine: classification, learning
// and lookup sequencer. Depends on lbvf_pkg, lbvf_ram and lbvf_set_mod.
`default_nettype none
//
//  Channel   Ports                                  Carries
//  input     s_valid, s_ready, s_payload (in_t)     frame header or membership write
//  result    m_valid, m_ready, m_payload (out_t)    forwarding decision
//  config    cfg_valid, cfg_ready, cfg_index/data   register write, always ready
//
// A membership write or early drop goes straight to the output state; a
// membership or IPv4-room drop waits on the source set index first; a
// broadcast destination adds the learn write, and a full lookup then the
// destination set index wait and the check. Unless the set count is a power
// of two, set index waits use the two-stage reciprocal unit. The next item
// is accepted in the cycle after the result is loaded at the earliest. After
// reset a clearing pass over the SET_COUNT rows (256 by default) zeroes the
// table; no item is accepted during it. A stalled result holds the engine in
// its final state, while the finished result register lets the next item in.
module l2_learning_bridge_vlan_fdb_unit #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_WAYS    = 4,
    parameter int PORT_BITS     = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire lbvf_pkg::in_t   s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lbvf_pkg::out_t       m_payload,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [39:0]     cfg_data
);
    localparam int SET_COUNT = TABLE_ENTRIES / TABLE_WAYS;
    localparam int SET_W     = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W     = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;
    localparam int LVL       = $clog2(TABLE_WAYS);
    localparam int PAD       = 1 << LVL;
    localparam int LRU_W     = PAD > 1 ? PAD - 1 : 1;
    localparam int KW        = lbvf_pkg::KEY_W;
    // Entry layout, top down: valid, key, stamp, tagged flag, port.
    localparam int ENT_W     = 1 + KW + 64 + 1 + PORT_BITS;
    localparam int ROW_W     = LRU_W + TABLE_WAYS * ENT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHASH = 3'd1;
    localparam logic [2:0] ST_LEARN = 3'd2;
    localparam logic [2:0] ST_DHASH = 3'd3;
    localparam logic [2:0] ST_DCHK  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // Tree pseudo-LRU: pick the victim way by following the node bits.
    function automatic logic [WAY_W-1:0] lru_victim(input logic [LRU_W-1:0] bits);
        int node;
        int lo;
        int size;
        int half;
        logic right;
        node = 1;
        lo   = 0;
        size = PAD;
        for (int s = 0; s < LVL; s++) begin
            half  = size / 2;
            right = bits[node-1];
            if (right && (lo + half >= TABLE_WAYS)) begin
                right = 1'b0;
            end
            if (right) begin
                node = node * 2 + 1;
                lo   = lo + half;
            end else begin
                node = node * 2;
            end
            size = half;
        end
        return WAY_W'(lo);
    endfunction

    // Mark a way as most recently used along its path.
    function automatic logic [LRU_W-1:0] lru_touch(input logic [LRU_W-1:0] bits,
                                                   input logic [WAY_W-1:0] way);
        int node;
        int lo;
        int size;
        int half;
        logic [LRU_W-1:0] b;
        node = 1;
        lo   = 0;
        size = PAD;
        b    = bits;
        for (int s = 0; s < LVL; s++) begin
            half = size / 2;
            if (int'(way) < lo + half) begin
                b[node-1] = 1'b1;
                node      = node * 2;
            end else begin
                b[node-1] = 1'b0;
                node      = node * 2 + 1;
                lo        = lo + half;
            end
            size = half;
        end
        return b;
    endfunction

    // Configuration registers.
    logic [7:0]  own_port_reg;
    logic [11:0] port_vlan_reg;
    logic        filter_reg;
    logic        hook_reg;
    logic [39:0] max_age_reg;

    // Sequencer and item registers.
    logic [2:0]       state_reg, state_next;
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [11:0]      vlan_reg;
    logic             tagged_reg;
    logic             short_ip_reg;
    logic [47:0]      dmac_reg;
    logic [KW-1:0]    skey_reg;
    logic [63:0]      now_reg;
    logic [SET_W-1:0] set_reg;
    lbvf_pkg::out_t   res_reg, res_next;
    logic             m_valid_reg;
    lbvf_pkg::out_t   m_payload_reg;
    logic [63:0]      mem_valid_reg;

    // Memories and the set index unit.
    logic             tbl_we, tbl_re;
    logic [SET_W-1:0] tbl_waddr, tbl_raddr;
    logic [ROW_W-1:0] tbl_wdata, tbl_rdata;
    logic             mbr_we, mbr_re;
    logic [63:0]      mbr_rdata;
    logic             hash_start;
    logic [lbvf_pkg::HASH_W-1:0] hash_in;
    logic             hash_done;
    logic [SET_W-1:0] hash_rem;

    // Classification of the item at the input.
    logic        accept;
    logic        is_q, is_ad;
    logic [11:0] tag_vid, cls_vlan;
    logic        early_drop;
    logic [2:0]  early_reason;
    logic [11:0] early_vlan;
    logic [KW-1:0] src_key;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        is_q     = s_payload.outer_type == lbvf_pkg::TPID_Q;
        is_ad    = s_payload.outer_type == lbvf_pkg::TPID_AD;
        tag_vid  = s_payload.tag_control[11:0];
        cls_vlan = is_q ? tag_vid : port_vlan_reg;
        src_key  = {cls_vlan, s_payload.source_mac};
        early_drop   = 1'b1;
        early_reason = lbvf_pkg::DROP_NONE;
        early_vlan   = port_vlan_reg;
        if (s_payload.frame_length < lbvf_pkg::LEN_UNTAGGED) begin
            early_reason = lbvf_pkg::DROP_SHORT;
        end else if ((is_q || is_ad) && s_payload.frame_length < lbvf_pkg::LEN_TAGGED) begin
            early_reason = lbvf_pkg::DROP_SHORT;
        end else if (is_q && (tag_vid == 12'd0 || tag_vid > lbvf_pkg::VID_MAX)) begin
            early_reason = lbvf_pkg::DROP_BAD_VLAN;
            early_vlan   = tag_vid;
        end else if (is_ad) begin
            early_reason = lbvf_pkg::DROP_QINQ;
        end else begin
            early_drop = 1'b0;
        end
    end

    // The membership word is read at acceptance and checked in the set index wait.
    logic mbr_ok;
    assign mbr_we = accept && (s_payload.cmd == lbvf_pkg::CMD_MEMBER);
    assign mbr_re = accept;
    always_comb begin
        mbr_ok = !filter_reg || !tagged_reg || (vlan_reg == port_vlan_reg)
                 || (mem_valid_reg[vlan_reg[11:6]] && mbr_rdata[vlan_reg[5:0]]);
    end

    lbvf_ram #(.WIDTH(64), .DEPTH(64)) u_mbr_ram (
        .aclk  (aclk),
        .we    (mbr_we),
        .waddr (s_payload.member_word_index),
        .wdata (s_payload.member_word_bits),
        .re    (mbr_re),
        .raddr (s_payload.tag_control[11:6]),
        .rdata (mbr_rdata)
    );

    // Set index: the source key at acceptance, the destination key after learning.
    logic [KW-1:0] dkey;
    assign dkey       = {vlan_reg, dmac_reg};
    assign hash_start = (accept && s_payload.cmd != lbvf_pkg::CMD_MEMBER && !early_drop)
                        || (state_reg == ST_LEARN
                            && dmac_reg[47:40] != lbvf_pkg::BCAST_OCTET);
    assign hash_in    = (state_reg == ST_IDLE) ? lbvf_pkg::fold_key(src_key)
                                               : lbvf_pkg::fold_key(dkey);

    lbvf_set_mod #(.DIVISOR(SET_COUNT), .OUT_W(SET_W)) u_set_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .value   (hash_in),
        .done    (hash_done),
        .rem     (hash_rem)
    );

    // Learning: overwrite a hit, else fill the first free way, else evict.
    logic [LRU_W-1:0] row_lru;
    logic             l_hit, l_free;
    logic [WAY_W-1:0] l_hit_w, l_free_w, l_way;
    logic [ENT_W-1:0] l_ent, e_tmp;
    logic [ROW_W-1:0] learn_row;
    logic [15:0]      own_wide;

    assign row_lru  = tbl_rdata[ROW_W-1 -: LRU_W];
    assign own_wide = {8'd0, own_port_reg};

    always_comb begin
        l_hit    = 1'b0;
        l_free   = 1'b0;
        l_hit_w  = '0;
        l_free_w = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            e_tmp = tbl_rdata[w*ENT_W +: ENT_W];
            if (e_tmp[ENT_W-1] && e_tmp[ENT_W-2 -: KW] == skey_reg) begin
                l_hit   = 1'b1;
                l_hit_w = WAY_W'(w);
            end
            if (!e_tmp[ENT_W-1]) begin
                l_free   = 1'b1;
                l_free_w = WAY_W'(w);
            end
        end
        l_way = l_hit ? l_hit_w : (l_free ? l_free_w : lru_victim(row_lru));
        l_ent = {1'b1, skey_reg, now_reg, tagged_reg, own_wide[PORT_BITS-1:0]};
        learn_row = tbl_rdata;
        learn_row[ROW_W-1 -: LRU_W] = lru_touch(row_lru, l_way);
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (l_way == WAY_W'(w)) begin
                learn_row[w*ENT_W +: ENT_W] = l_ent;
            end
        end
    end

    // Destination lookup, aging and tag edit.
    logic             d_hit;
    logic [WAY_W-1:0] d_way;
    logic [ENT_W-1:0] d_ent, d_tmp;
    logic [63:0]      d_stamp;
    logic             d_expired;
    logic             d_tagged;
    logic [15:0]      d_port_wide;
    logic [ROW_W-1:0] dchk_row;
    logic [1:0]       d_edit;

    always_comb begin
        d_hit = 1'b0;
        d_way = '0;
        d_ent = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            d_tmp = tbl_rdata[w*ENT_W +: ENT_W];
            if (d_tmp[ENT_W-1] && d_tmp[ENT_W-2 -: KW] == dkey) begin
                d_hit = 1'b1;
                d_way = WAY_W'(w);
                d_ent = d_tmp;
            end
        end
        d_stamp     = d_ent[PORT_BITS+64 -: 64];
        d_expired   = (now_reg > d_stamp) && ((now_reg - d_stamp) > {24'd0, max_age_reg});
        d_tagged    = d_ent[PORT_BITS];
        d_port_wide = 16'(d_ent[PORT_BITS-1:0]);
        if (d_tagged && !tagged_reg) begin
            d_edit = lbvf_pkg::EDIT_PUSH;
        end else if (!d_tagged && tagged_reg) begin
            d_edit = lbvf_pkg::EDIT_POP;
        end else begin
            d_edit = lbvf_pkg::EDIT_NONE;
        end
        dchk_row = tbl_rdata;
        dchk_row[ROW_W-1 -: LRU_W] = lru_touch(row_lru, d_way);
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (d_way == WAY_W'(w) && d_expired) begin
                dchk_row[w*ENT_W + ENT_W - 1] = 1'b0;
            end
        end
    end

    // Table port control: clearing, row reads, learn write, LRU and aging write-back.
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = set_reg;
        tbl_wdata = learn_row;
        tbl_re    = 1'b0;
        tbl_raddr = hash_rem;
        if (clr_busy_reg) begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = '0;
        end else begin
            case (state_reg)
                ST_SHASH: begin
                    tbl_re = hash_done && mbr_ok && !short_ip_reg;
                end
                ST_LEARN: begin
                    tbl_we = 1'b1;
                end
                ST_DHASH: begin
                    tbl_re = hash_done;
                end
                ST_DCHK: begin
                    tbl_we    = d_hit;
                    tbl_wdata = dchk_row;
                end
                default: begin
                    tbl_we = 1'b0;
                end
            endcase
        end
    end

    lbvf_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_payload.cmd == lbvf_pkg::CMD_MEMBER || early_drop) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SHASH;
                    end
                end
            end
            ST_SHASH: begin
                if (hash_done) begin
                    state_next = (mbr_ok && !short_ip_reg) ? ST_LEARN : ST_OUT;
                end
            end
            ST_LEARN: begin
                state_next = (dmac_reg[47:40] == lbvf_pkg::BCAST_OCTET) ? ST_OUT : ST_DHASH;
            end
            ST_DHASH: begin
                if (hash_done) begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result under construction: seeded at acceptance, then refined by
    // the membership and length checks and by the destination lookup.
    always_comb begin
        res_next = res_reg;
        if (accept) begin
            res_next = '0;
            if (s_payload.cmd == lbvf_pkg::CMD_MEMBER) begin
                res_next.action = lbvf_pkg::ACT_CFG_DONE;
            end else begin
                res_next.action      = lbvf_pkg::ACT_DROP;
                res_next.frame_vlan  = early_vlan;
                res_next.drop_reason = early_reason;
            end
        end
        case (state_reg)
            ST_SHASH: begin
                res_next.frame_vlan = vlan_reg;
                if (!mbr_ok) begin
                    res_next.drop_reason = lbvf_pkg::DROP_NOT_MEM;
                end else if (short_ip_reg) begin
                    res_next.drop_reason = lbvf_pkg::DROP_NO_IPV4;
                end else begin
                    res_next.action = lbvf_pkg::ACT_PASS;
                end
            end
            ST_DCHK: begin
                if (d_hit && !d_expired) begin
                    res_next.action   = hook_reg ? lbvf_pkg::ACT_HOOK
                                                 : lbvf_pkg::ACT_REDIRECT;
                    res_next.out_port = d_port_wide[7:0];
                    res_next.tag_edit = d_edit;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            mem_valid_reg <= '0;
            own_port_reg  <= 8'd0;
            port_vlan_reg <= lbvf_pkg::PVID_INIT;
            filter_reg    <= 1'b0;
            hook_reg      <= 1'b0;
            max_age_reg   <= lbvf_pkg::MAX_AGE_INIT;
        end else begin
            state_reg <= state_next;
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(SET_COUNT - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (mbr_we) begin
                mem_valid_reg[s_payload.member_word_index] <= 1'b1;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    lbvf_pkg::CFG_OWN_PORT:  own_port_reg  <= cfg_data[7:0];
                    lbvf_pkg::CFG_PORT_VLAN: port_vlan_reg <= cfg_data[11:0];
                    lbvf_pkg::CFG_FILTER:    filter_reg    <= cfg_data[0];
                    lbvf_pkg::CFG_HOOK:      hook_reg      <= cfg_data[0];
                    lbvf_pkg::CFG_MAX_AGE:   max_age_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end

        // Payload registers.
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_payload_reg <= res_reg;
        end
        res_reg <= res_next;
        if (accept) begin
            vlan_reg     <= cls_vlan;
            tagged_reg   <= is_q;
            short_ip_reg <= s_payload.frame_length
                            < (is_q ? lbvf_pkg::LEN_IP_TAG : lbvf_pkg::LEN_IP_UNTAG);
            dmac_reg     <= s_payload.dest_mac;
            skey_reg     <= src_key;
            now_reg      <= s_payload.now_ns;
        end
        case (state_reg)
            ST_SHASH: begin
                set_reg <= hash_rem;
            end
            ST_DHASH: begin
                set_reg <= hash_rem;
            end
            default: begin
            end
        endcase
    end

    // No item enters while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("item accepted during clearing pass");

    // The set index unit only finishes while the sequencer waits for it.
    a_hash_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> (state_reg == ST_SHASH || state_reg == ST_DHASH))
        else $error("set index ready outside a hash wait state");

    // Table read and write never fall in the same cycle.
    a_tbl_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_we && tbl_re))
        else $error("table read and write in one cycle");

    // A learn write is always followed by a result or a destination lookup.
    a_learn_then: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEARN) |=> (state_reg == ST_OUT || state_reg == ST_DHASH))
        else $error("bad sequence after learn");

endmodule
`default_nettype wire

// ----- tb/sv/l2_learning_bridge_vlan_fdb_unit_tb.sv -----
// Self-checking testbench for the learning bridge ingress engine.
// Depends on lbvf_pkg and l2_learning_bridge_vlan_fdb_unit only.
module l2_learning_bridge_vlan_fdb_unit_tb;

    localparam int ENTRIES = 1024;
    localparam int WAYS    = 4;
    localparam int SETS    = ENTRIES / WAYS;
    localparam int PHASES  = 7;

    // Forwarding table model. It keeps its own copy of the registers, the
    // table, the pseudo-LRU bits and the VLAN membership words, and queues
    // the decision that each accepted item must produce.
    class fdb_scoreboard;
        logic [7:0]  own_port;
        logic [11:0] port_vlan;
        bit          filter_en;
        bit          hook_en;
        logic [39:0] max_age;
        logic [59:0] key_mem[ENTRIES];
        bit          valid_mem[ENTRIES];
        logic [63:0] stamp_mem[ENTRIES];
        logic [8:0]  port_mem[ENTRIES];
        logic [2:0]  lru[SETS];
        logic [63:0] member[64];
        lbvf_pkg::out_t pending[$];
        int          errors;
        int          checked;

        function new();
            own_port  = 8'd0;
            port_vlan = 12'd1;
            filter_en = 1'b0;
            hook_en   = 1'b0;
            max_age   = 40'd300000000000;
            foreach (valid_mem[i]) valid_mem[i] = 1'b0;
            foreach (lru[i]) lru[i] = 3'd0;
            foreach (member[i]) member[i] = 64'd0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [39:0] data);
            case (idx)
                lbvf_pkg::CFG_OWN_PORT:  own_port  = data[7:0];
                lbvf_pkg::CFG_PORT_VLAN: port_vlan = data[11:0];
                lbvf_pkg::CFG_FILTER:    filter_en = data[0];
                lbvf_pkg::CFG_HOOK:      hook_en   = data[0];
                lbvf_pkg::CFG_MAX_AGE:   max_age   = data;
                default: ;
            endcase
        endfunction

        function int set_of_key(logic [59:0] k);
            logic [19:0] h;
            h = k[19:0] ^ k[39:20] ^ k[59:40];
            return h % SETS;
        endfunction

        // Walk toward the way, pointing each node on the path away from it.
        function void mark_used(int set, int way);
            int node, lo, size, half;
            node = 1;
            lo   = 0;
            size = WAYS;
            while (size > 1) begin
                half = size / 2;
                if (way < lo + half) begin
                    lru[set][node-1] = 1'b1;
                    node = node * 2;
                end else begin
                    lru[set][node-1] = 1'b0;
                    node = node * 2 + 1;
                    lo += half;
                end
                size = half;
            end
        endfunction

        function int pick_victim(int set);
            int node, lo, size, half;
            node = 1;
            lo   = 0;
            size = WAYS;
            while (size > 1) begin
                half = size / 2;
                if (lru[set][node-1] && lo + half < WAYS) begin
                    node = node * 2 + 1;
                    lo += half;
                end else begin
                    node = node * 2;
                end
                size = half;
            end
            return lo;
        endfunction

        function int lookup_way(int set, logic [59:0] k);
            for (int w = 0; w < WAYS; w++)
                if (valid_mem[set*WAYS+w] && key_mem[set*WAYS+w] == k) return w;
            return -1;
        endfunction

        function void learn_source(logic [59:0] k, logic [63:0] now, bit is_tag);
            int set, w, i;
            set = set_of_key(k);
            w = lookup_way(set, k);
            if (w < 0) begin
                w = WAYS;
                for (int j = WAYS - 1; j >= 0; j--)
                    if (!valid_mem[set*WAYS+j]) w = j;
                if (w == WAYS) w = pick_victim(set);
            end
            i = set * WAYS + w;
            key_mem[i]   = k;
            valid_mem[i] = 1'b1;
            stamp_mem[i] = now;
            port_mem[i]  = {is_tag, own_port};
            mark_used(set, w);
        endfunction

        function lbvf_pkg::out_t decide(lbvf_pkg::in_t it);
            lbvf_pkg::out_t r;
            logic [11:0] vlan;
            bit          is_tag;
            int          need, set, w, i;
            logic [59:0] dkey;
            r = '0;
            vlan = port_vlan;
            is_tag = 1'b0;
            need = 34;
            if (it.cmd == lbvf_pkg::CMD_MEMBER) begin
                member[it.member_word_index] = it.member_word_bits;
                r.action = lbvf_pkg::ACT_CFG_DONE;
                return r;
            end
            r.action = lbvf_pkg::ACT_DROP;
            r.frame_vlan = vlan;
            if (it.frame_length < 14) begin
                r.drop_reason = lbvf_pkg::DROP_SHORT;
                return r;
            end
            if (it.outer_type == lbvf_pkg::TPID_Q) begin
                is_tag = 1'b1;
                need = 38;
                if (it.frame_length < 18) begin
                    r.drop_reason = lbvf_pkg::DROP_SHORT;
                    return r;
                end
                vlan = it.tag_control[11:0];
                r.frame_vlan = vlan;
                if (vlan == 12'd0 || vlan == 12'hfff) begin
                    r.drop_reason = lbvf_pkg::DROP_BAD_VLAN;
                    return r;
                end
                if (filter_en && vlan != port_vlan && !member[vlan[11:6]][vlan[5:0]]) begin
                    r.drop_reason = lbvf_pkg::DROP_NOT_MEM;
                    return r;
                end
            end else if (it.outer_type == lbvf_pkg::TPID_AD) begin
                r.drop_reason = (it.frame_length < 18) ? lbvf_pkg::DROP_SHORT
                                                       : lbvf_pkg::DROP_QINQ;
                return r;
            end
            if (it.frame_length < need) begin
                r.drop_reason = lbvf_pkg::DROP_NO_IPV4;
                return r;
            end
            learn_source({vlan, it.source_mac}, it.now_ns, is_tag);
            r.action = lbvf_pkg::ACT_PASS;
            if (it.dest_mac[47:40] == 8'hff) return r;
            dkey = {vlan, it.dest_mac};
            set = set_of_key(dkey);
            w = lookup_way(set, dkey);
            if (w < 0) return r;
            i = set * WAYS + w;
            mark_used(set, w);
            // An entry stamped later than the current time never expires.
            if (it.now_ns > stamp_mem[i] && it.now_ns - stamp_mem[i] > {24'd0, max_age}) begin
                valid_mem[i] = 1'b0;
                return r;
            end
            r.action = hook_en ? lbvf_pkg::ACT_HOOK : lbvf_pkg::ACT_REDIRECT;
            r.out_port = port_mem[i][7:0];
            if (port_mem[i][8] && !is_tag) r.tag_edit = lbvf_pkg::EDIT_PUSH;
            else if (!port_mem[i][8] && is_tag) r.tag_edit = lbvf_pkg::EDIT_POP;
            return r;
        endfunction

        function void note_item(lbvf_pkg::in_t it);
            pending.push_back(decide(it));
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(lbvf_pkg::out_t got);
            lbvf_pkg::out_t want;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.out_port !== want.out_port)
                report($sformatf("out_port %0d, want %0d", got.out_port, want.out_port));
            if (got.tag_edit !== want.tag_edit)
                report($sformatf("tag_edit %0d, want %0d", got.tag_edit, want.tag_edit));
            if (got.frame_vlan !== want.frame_vlan)
                report($sformatf("frame_vlan %0d, want %0d", got.frame_vlan, want.frame_vlan));
            if (got.drop_reason !== want.drop_reason)
                report($sformatf("drop_reason %0d, want %0d", got.drop_reason,
                                 want.drop_reason));
        endtask
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    lbvf_pkg::in_t  s_payload = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    lbvf_pkg::out_t m_payload;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [2:0]     cfg_index = lbvf_pkg::CFG_OWN_PORT;
    logic [39:0]    cfg_data = '0;

    fdb_scoreboard fdb = new();
    // When set, neither side idles; one phase runs entirely this way.
    bit            quiet = 1'b0;
    logic [47:0]   mac_pool[16];
    logic [63:0]   now_cnt = 64'd0;
    int            items_sent = 0;

    always #6 aclk = ~aclk;

    l2_learning_bridge_vlan_fdb_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The result side stalls at random, and every accepted result is checked
    // against the oldest queued decision at the rising edge.
    always @(negedge aclk) begin
        m_ready = quiet || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) fdb.check_result(m_payload);
    end

    // Offer one item, with an occasional random gap first. The valid stays
    // high after acceptance so that back-to-back items need no toggle; the
    // caller lowers it once the stream ends.
    task send_item(lbvf_pkg::in_t it);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = it;
        do @(posedge aclk); while (!s_ready);
        fdb.note_item(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task stop_and_drain();
        s_valid = 1'b0;
        while (fdb.pending.size() != 0) @(negedge aclk);
        // Let the engine settle before anything that needs it idle.
        repeat (60) @(negedge aclk);
    endtask

    task write_reg(logic [2:0] idx, logic [39:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        fdb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function lbvf_pkg::in_t frame(int len, logic [15:0] otype, logic [15:0] tci,
                                  logic [47:0] dmac, logic [47:0] smac, logic [63:0] now);
        lbvf_pkg::in_t it;
        it = '0;
        it.frame_length = len[13:0];
        it.outer_type   = otype;
        it.tag_control  = tci;
        it.dest_mac     = dmac;
        it.source_mac   = smac;
        it.now_ns       = now;
        return it;
    endfunction

    function logic [11:0] pick_vlan();
        case ($urandom_range(0, 9))
            0, 1, 2: return fdb.port_vlan;
            3:       return 12'd0;
            4:       return 12'hfff;
            5:       return 12'd4094;
            6:       return 12'($urandom);
            default: return 12'($urandom_range(1, 6));
        endcase
    endfunction

    // Mostly well-formed frames among a small set of stations so that the
    // table sees hits, aging and replacement; the rest is broken or random.
    function lbvf_pkg::in_t random_item(logic [31:0] step_max);
        lbvf_pkg::in_t it;
        int  r;
        it = '0;
        it.member_word_index = 6'($urandom);
        it.member_word_bits  = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 5) begin
            it.cmd = lbvf_pkg::CMD_MEMBER;
            if ($urandom_range(0, 1)) it.member_word_index = 6'($urandom_range(0, 1));
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 8)       it.frame_length = 14'($urandom_range(0, 40));
        else if (r < 10) it.frame_length = 14'($urandom);
        else             it.frame_length = 14'($urandom_range(60, 1518));
        r = $urandom_range(0, 99);
        if (r < 50)      it.outer_type = lbvf_pkg::TPID_Q;
        else if (r < 58) it.outer_type = lbvf_pkg::TPID_AD;
        else if (r < 90) it.outer_type = 16'h0800;
        else             it.outer_type = 16'($urandom);
        it.tag_control = {4'($urandom), pick_vlan()};
        r = $urandom_range(0, 99);
        if (r < 70)      it.dest_mac = mac_pool[$urandom_range(0, 15)];
        else if (r < 80) it.dest_mac = {8'hff, 40'({$urandom, $urandom})};
        else             it.dest_mac = 48'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 80) it.source_mac = mac_pool[$urandom_range(0, 15)];
        else                            it.source_mac = 48'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 3) begin
            it.now_ns = {$urandom, $urandom};
        end else if (r < 6) begin
            it.now_ns = now_cnt - 64'($urandom_range(0, step_max));
        end else begin
            now_cnt += 64'($urandom_range(0, step_max));
            it.now_ns = now_cnt;
        end
        return it;
    endfunction

    initial begin
        logic [7:0]  ph_port[PHASES]   = '{8'd5, 8'd0, 8'd255, 8'd17, 8'd128, 8'd1, 8'd200};
        logic [11:0] ph_vlan[PHASES]   = '{12'd1, 12'd1, 12'hfff, 12'd0, 12'd4094, 12'd100,
                                           12'd2};
        bit          ph_filter[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        bit          ph_hook[PHASES]   = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        logic [39:0] ph_age[PHASES]    = '{40'd100, 40'd300000000000, 40'd0,
                                           40'hffffffffff, 40'd1000, 40'd50, 40'd5000};
        logic [31:0] ph_step[PHASES]   = '{32'd40, 32'd2000000000, 32'd3, 32'd1000000000,
                                           32'd300, 32'd30, 32'd500};
        logic [47:0]   sta_a;
        logic [47:0]   sta_b;
        lbvf_pkg::in_t mw;

        foreach (mac_pool[i]) mac_pool[i] = {8'($urandom) & 8'hfe, 40'({$urandom, $urandom})};
        sta_a = mac_pool[0];
        sta_b = mac_pool[1];

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            write_reg(lbvf_pkg::CFG_OWN_PORT, {32'd0, ph_port[p]});
            write_reg(lbvf_pkg::CFG_PORT_VLAN, {28'd0, ph_vlan[p]});
            write_reg(lbvf_pkg::CFG_FILTER, {39'd0, ph_filter[p]});
            write_reg(lbvf_pkg::CFG_HOOK, {39'd0, ph_hook[p]});
            write_reg(lbvf_pkg::CFG_MAX_AGE, ph_age[p]);
            quiet = (p == 3);

            if (p == 0) begin
                // Directed frames: membership write, every drop reason, the
                // tag edits, broadcast, unknown and an expired destination.
                mw = '0;
                mw.cmd = lbvf_pkg::CMD_MEMBER;
                mw.member_word_index = 6'd0;
                mw.member_word_bits  = 64'h4;
                send_item(mw);
                send_item(frame(13, 16'h0800, 16'h0, sta_b, sta_a, 64'd1));
                send_item(frame(17, lbvf_pkg::TPID_Q, 16'h0002, sta_b, sta_a, 64'd1));
                send_item(frame(17, lbvf_pkg::TPID_AD, 16'h0002, sta_b, sta_a, 64'd1));
                send_item(frame(64, lbvf_pkg::TPID_AD, 16'h0002, sta_b, sta_a, 64'd1));
                send_item(frame(64, lbvf_pkg::TPID_Q, 16'hf000, sta_b, sta_a, 64'd1));
                send_item(frame(64, lbvf_pkg::TPID_Q, 16'h0fff, sta_b, sta_a, 64'd1));
                send_item(frame(64, lbvf_pkg::TPID_Q, 16'h0003, sta_b, sta_a, 64'd1));
                send_item(frame(37, lbvf_pkg::TPID_Q, 16'h0002, sta_b, sta_a, 64'd1));
                send_item(frame(33, 16'h0800, 16'h0, sta_b, sta_a, 64'd1));
                send_item(frame(14, 16'h0800, 16'h0, sta_b, sta_a, 64'd1));
                send_item(frame(60, 16'h0800, 16'h0, sta_b, sta_a, 64'd10));
                send_item(frame(60, 16'h0800, 16'h0, sta_a, sta_b, 64'd20));
                send_item(frame(60, lbvf_pkg::TPID_Q, 16'he001, sta_b, sta_b, 64'd30));
                send_item(frame(60, 16'h0800, 16'h0, sta_b, sta_a, 64'd40));
                send_item(frame(60, lbvf_pkg::TPID_Q, 16'h0001, sta_a, sta_b, 64'd50));
                send_item(frame(60, lbvf_pkg::TPID_Q, 16'h0002, sta_a, sta_a, 64'd60));
                send_item(frame(60, 16'h0800, 16'h0, 48'hffffffffffff, sta_b, 64'd70));
                send_item(frame(60, 16'h0800, 16'h0, mac_pool[5], sta_b, 64'd80));
                send_item(frame(60, 16'h0800, 16'h0, sta_a, sta_b, 64'd500));
                send_item(frame(60, 16'h0800, 16'h0, sta_a, sta_b, 64'd510));
                send_item(frame(16383, lbvf_pkg::TPID_Q, 16'hffff, 48'hffffffffffff,
                                48'hffffffffffff, 64'hffffffffffffffff));
                now_cnt = 64'd1000;
            end

            for (int n = 0; n < 250; n++) begin
                send_item(random_item(ph_step[p]));
                // Once in the run, hold off until the engine has answered all.
                if (p == 4 && n == 120) stop_and_drain();
            end
            stop_and_drain();
        end

        $display("Ran %0d items over %0d register settings; %0d results checked.",
                 items_sent, PHASES, fdb.checked);
        $display("Covered every drop reason, tag push and pop, hook, aging and replacement.");
        if (fdb.errors == 0) begin
            $display("l2_learning_bridge_vlan_fdb_unit verification clean");
        end else begin
            $display("l2_learning_bridge_vlan_fdb_unit verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #(12 * 600000);
        $display("Timeout with %0d results outstanding.", fdb.pending.size());
        $display("l2_learning_bridge_vlan_fdb_unit verification failed");
        $finish;
    end

endmodule
